>>> rtl/masked_byte_pattern_search_macros.svh
// assertion macros used by the checker file
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// checked on every clock edge outside reset
`define MBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define MBPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/mbps_pkg.sv
// types and constants of the masked byte pattern search
package mbps_pkg;

  localparam int unsigned PatBytes  = 16;
  localparam int unsigned PatIdxW   = 4;
  localparam int unsigned LenW      = 5;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned OffsetW   = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_MASK   = 2'd2,
    REG_LEN    = 2'd3
  } cfg_reg_e;

  localparam logic [PatBytes-1:0] MaskReset = '1;
  localparam logic [LenW-1:0]     LenReset  = LenW'(1);

  typedef struct packed {
    logic [PatBytes-1:0][7:0] pat;
    logic [PatBytes-1:0]      mask;
    logic [LenW-1:0]          len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       range_last;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [OffsetW-1:0] match_offset;
  } out_beat_t;

endpackage

>>> rtl/mbps_cfg.sv
// pattern, compare mask and length registers
module mbps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_wdata_i,
  output mbps_pkg::cfg_t                cfg_o
);
  import mbps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PAT_LO: cfg_d.pat[7:0]  = cfg_wdata_i;
        REG_PAT_HI: cfg_d.pat[15:8] = cfg_wdata_i;
        REG_MASK:   cfg_d.mask      = cfg_wdata_i[PatBytes-1:0];
        REG_LEN:    cfg_d.len       = cfg_wdata_i[LenW-1:0];
        default:    cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat  <= '0;
      cfg_q.mask <= MaskReset;
      cfg_q.len  <= LenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/mbps_cell.sv
// one window position: holds a byte, passes it on, checks it against its pattern byte
module mbps_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [7:0]                 byte_i,
  input  logic [mbps_pkg::LenW-1:0]  len_i,
  input  mbps_pkg::cfg_t             cfg_i,
  output logic [7:0]                 byte_o,
  output logic                       ok_o
);
  import mbps_pkg::*;

  localparam logic [LenW-1:0] CellPos = LenW'(IDX);

  logic [7:0]         byte_q;
  logic [LenW-1:0]    sel;
  logic [PatIdxW-1:0] pidx;
  logic               in_use;

  // window position k lines up with pattern byte len-1-k
  assign in_use = CellPos < len_i;
  assign sel    = len_i - LenW'(1) - CellPos;
  assign pidx   = sel[PatIdxW-1:0];
  assign ok_o   = !in_use || !cfg_i.mask[pidx] || (byte_i == cfg_i.pat[pidx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

>>> rtl/masked_byte_pattern_search.sv
// masked byte pattern search: top level with cell row, offset counter and result register
//
//   channel  | direction | handshake              | beat
//   cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//   in       | in        | in_valid_i/in_ready_o  | in_data_i (data_byte, range_last)
//   out      | out       | out_valid_o/out_ready_i| out_data_o (found, match_offset)
//
// one byte per cycle while in_ready_o is high: the new byte enters the cell row and all cells compare in the same
// cycle; a result appears in the output register the cycle after its byte.
// reset clears the window, the offset counter, the reported flag and the output register,
// and loads the register defaults.
// in_ready_o drops only while a result waits in the output register and out_ready_i is low.
module masked_byte_pattern_search #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mbps_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mbps_pkg::out_beat_t           out_data_o
);
  import mbps_pkg::*;

  localparam int unsigned NumCells =
    (MAX_PATTERN_BYTES < PatBytes) ? MAX_PATTERN_BYTES : PatBytes;
  localparam int unsigned CntW = OFFSET_BITS;

  cfg_t             cfg;
  logic [LenW-1:0]  len_eff;
  logic             accept;
  logic [7:0]       cell_byte [NumCells];
  logic [NumCells-1:0] cell_ok;
  logic             win_match;

  logic [CntW-1:0]  seen_q, seen_d, seen_inc, diff;
  logic             rep_q, rep_d;
  logic             hit, emit;
  logic [OffsetW-1:0] offset;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_data_q, out_data_d;

  mbps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // lengths above the row size use the whole row
  assign len_eff = (cfg.len > LenW'(NumCells)) ? LenW'(NumCells) : cfg.len;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic [7:0] nb;
    if (i == 0) begin : g_head
      assign nb = in_data_i.data_byte;
    end else begin : g_link
      assign nb = cell_byte[i-1];
    end
    mbps_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(accept),
      .byte_i (nb),
      .len_i  (len_eff),
      .cfg_i  (cfg),
      .byte_o (cell_byte[i]),
      .ok_o   (cell_ok[i])
    );
  end

  assign win_match = &cell_ok;

  // saturating count of bytes in the current range, this beat included
  assign seen_inc = (&seen_q) ? seen_q : seen_q + CntW'(1);
  assign diff     = seen_inc - CntW'(len_eff);

  if (CntW >= OffsetW) begin : g_off_wide
    assign offset = diff[OffsetW-1:0];
  end else begin : g_off_narrow
    assign offset = {{(OffsetW-CntW){1'b0}}, diff};
  end

  assign hit  = !rep_q && (len_eff != '0) && (seen_inc >= CntW'(len_eff)) && win_match;
  assign emit = hit || (in_data_i.range_last && !rep_q);

  always_comb begin
    seen_d      = seen_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      seen_d      = in_data_i.range_last ? '0 : seen_inc;
      rep_d       = in_data_i.range_last ? 1'b0 : (rep_q || hit);
      out_valid_d = emit;
      if (emit) begin
        out_data_d.found        = hit;
        out_data_d.match_offset = hit ? offset : '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      seen_q      <= seen_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/mbps_checker.sv
// port-level checks for the masked byte pattern search, bound to the top level
`include "masked_byte_pattern_search_macros.svh"

module mbps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mbps_pkg::out_beat_t out_data_o
);
  import mbps_pkg::*;

  // a stalled result stays put
  `MBPS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // a not-found result carries offset zero
  `MBPS_ASSERT(a_miss_zero, out_valid_o && !out_data_o.found |-> out_data_o.match_offset == '0, "not-found result with nonzero offset")

  // a fresh result always comes from an input beat taken on the previous edge
  `MBPS_ASSERT(a_out_from_in, out_valid_o && !$past(out_valid_o && !out_ready_i) |-> $past(in_valid_i && in_ready_o), "result without input beat")

  // an empty result register never blocks the input
  `MBPS_ASSERT_ALWAYS(a_ready_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (.*);

>>> tb/masked_byte_pattern_search_test.sv
`timescale 1ns / 1ps
// testbench for the masked byte pattern search: directed table, then random ranges
module masked_byte_pattern_search_test;
  import mbps_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int RandomBeats  = 1100;
  localparam int HoldAfter    = 600;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 4;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_RESULT
  } row_check_e;

  typedef struct {
    bit         is_cfg;
    cfg_reg_e   idx;
    logic [63:0] value;
    in_beat_t   beat;
    int         reps;
    row_check_e check;
    out_beat_t  res;
  } scan_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_beat_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_beat_t           out_data_o;

  masked_byte_pattern_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // scan state mirrored by the testbench
  logic [63:0] pat_lo_q   = '0;
  logic [63:0] pat_hi_q   = '0;
  logic [15:0] cmp_mask_q = MaskReset;
  logic [4:0]  pat_len_q  = LenReset;
  logic [7:0]  window_q [PatBytes] = '{default: 8'h00};
  logic [31:0] seen_q     = '0;
  bit          reported_q = 1'b0;

  out_beat_t pending_reports_q[$];
  scan_row_t scan_rows[$];

  int err_cnt    = 0;
  int beats_sent = 0;
  int hit_cnt    = 0;
  int miss_cnt   = 0;
  int cfg_cnt    = 0;
  int cycle_cnt  = 0;
  bit tx_calm    = 1'b0;
  bit rx_calm    = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] pattern_at(int k);
    return (k < 8) ? pat_lo_q[8*k +: 8] : pat_hi_q[8*(k-8) +: 8];
  endfunction

  // shifts one byte in and returns 1 when it produces a report
  function automatic bit scan_byte(input in_beat_t beat, output out_beat_t res);
    int eff;
    int i;
    bit hit;
    bit emit;
    eff  = (pat_len_q > 16) ? 16 : int'(pat_len_q);
    emit = 1'b0;
    res  = '0;
    for (i = PatBytes - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = beat.data_byte;
    if (seen_q != 32'hFFFF_FFFF) seen_q++;
    if (!reported_q && eff != 0 && seen_q >= 32'(eff)) begin
      hit = 1'b1;
      for (i = 0; i < eff; i++) begin
        if (cmp_mask_q[i] && window_q[eff-1-i] != pattern_at(i)) hit = 1'b0;
      end
      if (hit) begin
        res.found        = 1'b1;
        res.match_offset = seen_q - 32'(eff);
        reported_q       = 1'b1;
        emit             = 1'b1;
      end
    end
    if (beat.range_last) begin
      if (!reported_q) begin
        res  = '0;
        emit = 1'b1;
      end
      seen_q     = '0;
      reported_q = 1'b0;
    end
    return emit;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void cfg_row(cfg_reg_e idx, logic [63:0] value);
    scan_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.value  = value;
    row.beat   = '0;
    row.reps   = 0;
    row.check  = CHK_NONE;
    row.res    = '0;
    scan_rows.push_back(row);
  endfunction

  function automatic void byte_row(logic [7:0] data, bit last, int reps, row_check_e check,
                                   bit found, logic [31:0] offset);
    scan_row_t row;
    row.is_cfg               = 1'b0;
    row.idx                  = REG_PAT_LO;
    row.value                = '0;
    row.beat.data_byte       = data;
    row.beat.range_last      = last;
    row.reps                 = reps;
    row.check                = check;
    row.res.found            = found;
    row.res.match_offset     = offset;
    scan_rows.push_back(row);
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_PAT_LO: pat_lo_q   = value;
      REG_PAT_HI: pat_hi_q   = value;
      REG_MASK:   cmp_mask_q = value[15:0];
      REG_LEN:    pat_len_q  = value[4:0];
      default: ;
    endcase
    cfg_cnt++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid and wait until every report is out and the block has settled
  task automatic quiesce();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_reports_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic send_byte(input in_beat_t beat, input row_check_e chk, input out_beat_t typed);
    int gap;
    bit emit;
    out_beat_t res;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    emit = scan_byte(beat, res);
    beats_sent++;
    if (chk == CHK_MODEL && emit) begin
      pending_reports_q.push_back(res);
    end else if (chk == CHK_RESULT) begin
      pending_reports_q.push_back(typed);
    end
    @(negedge clk_i);
  endtask

  initial begin : rx_side
    int stall_left;
    int gap;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!held && beats_sent >= HoldAfter) begin
        // long hold-off so the output register fills and the input stalls
        held        = 1'b1;
        stall_left  = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        gap         = pick_gap(rx_calm);
        stall_left  = (gap > 0) ? gap - 1 : 0;
        out_ready_i <= (gap == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected report found=%0b offset=%0d", $time,
                 out_data_o.found, out_data_o.match_offset);
      end else begin
        want = pending_reports_q.pop_front();
        if (out_data_o.found !== want.found) begin
          err_cnt++;
          $display("%0t: found expected %0b got %0b", $time, want.found, out_data_o.found);
        end
        if (out_data_o.match_offset !== want.match_offset) begin
          err_cnt++;
          $display("%0t: match_offset expected %0d got %0d", $time, want.match_offset,
                   out_data_o.match_offset);
        end
        if (want.found) hit_cnt++;
        else miss_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_cnt,
               pending_reports_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    in_beat_t    beat;
    out_beat_t   none_res;
    row_check_e  chk;
    logic [63:0] value;
    logic [7:0]  bytes_q[$];
    int k, j, n, pos, eff, kind, r;
    int phase, phase_goal, phase_beats, rand_beats;

    none_res = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset pattern is a single 0x00 byte
    byte_row(8'hFF, 1, 1, CHK_RESULT, 1'b0, 0);
    byte_row(8'h00, 1, 1, CHK_RESULT, 1'b1, 0);  // hit on the last beat, no miss report
    byte_row(8'hFF, 0, 1, CHK_NONE,   1'b0, 0);
    byte_row(8'h00, 0, 1, CHK_RESULT, 1'b1, 1);
    byte_row(8'h00, 1, 1, CHK_NONE,   1'b0, 0);  // rest of the range is ignored after a hit
    cfg_row(REG_LEN, 64'd0);
    byte_row(8'h00, 1, 2, CHK_RESULT, 1'b0, 0);  // zero length never matches
    cfg_row(REG_PAT_LO, 64'h0000_0000_0000_BBAA);
    cfg_row(REG_LEN, 64'd2);
    byte_row(8'hAA, 1, 1, CHK_RESULT, 1'b0, 0);  // range shorter than the pattern
    byte_row(8'h11, 0, 1, CHK_NONE,   1'b0, 0);
    byte_row(8'hAA, 0, 1, CHK_NONE,   1'b0, 0);
    byte_row(8'hBB, 1, 1, CHK_RESULT, 1'b1, 1);
    cfg_row(REG_MASK, 64'h0002);
    byte_row(8'h55, 0, 1, CHK_NONE,   1'b0, 0);
    byte_row(8'hBB, 0, 1, CHK_RESULT, 1'b1, 0);  // first byte is a wildcard
    byte_row(8'hBB, 1, 1, CHK_NONE,   1'b0, 0);
    cfg_row(REG_PAT_LO, '1);
    cfg_row(REG_PAT_HI, '1);
    cfg_row(REG_MASK, 64'hFFFF);
    cfg_row(REG_LEN, 64'd31);
    byte_row(8'hFF, 1, 16, CHK_RESULT, 1'b1, 0);  // length above 16 clamps to 16
    cfg_row(REG_PAT_LO, 64'h0123_4567_89AB_CDEF);
    cfg_row(REG_PAT_HI, 64'hFEDC_BA98_7654_3210);
    cfg_row(REG_MASK, 64'hA5A5);
    cfg_row(REG_LEN, 64'd16);
    byte_row(8'hEF, 1, 3, CHK_MODEL, 1'b0, 0);

    foreach (scan_rows[i]) begin
      if (scan_rows[i].is_cfg) begin
        quiesce();
        write_reg(scan_rows[i].idx, scan_rows[i].value);
      end else begin
        for (k = 1; k <= scan_rows[i].reps; k++) begin
          beat            = scan_rows[i].beat;
          beat.range_last = scan_rows[i].beat.range_last && (k == scan_rows[i].reps);
          chk = (k < scan_rows[i].reps && scan_rows[i].check == CHK_RESULT) ?
                CHK_NONE : scan_rows[i].check;
          send_byte(beat, chk, scan_rows[i].res);
        end
      end
    end

    phase      = 0;
    rand_beats = 0;
    while (rand_beats < RandomBeats) begin
      quiesce();
      if (phase < 3 || $urandom_range(3, 0) != 0) begin
        write_reg(REG_PAT_LO, {$urandom, $urandom});
      end
      if (phase < 3 || $urandom_range(3, 0) != 0) begin
        write_reg(REG_PAT_HI, {$urandom, $urandom});
      end
      if (phase < 3 || $urandom_range(3, 0) != 0) begin
        value = $urandom_range(1, 0) ? {$urandom, $urandom} : '0;
        r = $urandom_range(99, 0);
        value[15:0] = (r < 35) ? 16'hFFFF : (r < 45) ? 16'h0000 : 16'($urandom);
        write_reg(REG_MASK, value);
      end
      if (phase < 3 || $urandom_range(3, 0) != 0) begin
        value = $urandom_range(1, 0) ? {$urandom, $urandom} : '0;
        r = $urandom_range(99, 0);
        if (phase == 0) value[4:0] = 5'd16;
        else if (phase == 1) value[4:0] = 5'd0;
        else if (phase == 2) value[4:0] = 5'($urandom_range(31, 17));
        else if (r < 60) value[4:0] = 5'($urandom_range(4, 1));
        else if (r < 85) value[4:0] = 5'($urandom_range(10, 5));
        else value[4:0] = 5'($urandom_range(16, 11));
        write_reg(REG_LEN, value);
      end
      tx_calm = ($urandom_range(4, 0) == 0);
      rx_calm = ($urandom_range(4, 0) == 0);
      eff = (pat_len_q > 16) ? 16 : int'(pat_len_q);
      phase_goal  = $urandom_range(140, 60);
      phase_beats = 0;
      while (phase_beats < phase_goal) begin
        // mostly ranges with the pattern planted, some broken, short or plain noise
        kind = $urandom_range(99, 0);
        if (kind >= 65 && kind < 80 && eff > 1) n = $urandom_range(eff - 1, 1);
        else if ($urandom_range(11, 0) == 0) n = $urandom_range(120, 40);
        else n = eff + $urandom_range(20, 0);
        if (n == 0) n = 1;
        bytes_q.delete();
        for (k = 0; k < n; k++) begin
          bytes_q.push_back($urandom_range(1, 0) ? pattern_at($urandom_range(15, 0)) :
                            8'($urandom));
        end
        if ((kind < 65 || (kind >= 80 && kind < 90)) && eff > 0 && n >= eff) begin
          pos = $urandom_range(n - eff, 0);
          for (j = 0; j < eff; j++) begin
            if (cmp_mask_q[j]) bytes_q[pos+j] = pattern_at(j);
          end
          if (kind >= 80) begin
            j = $urandom_range(eff - 1, 0);
            bytes_q[pos+j] = bytes_q[pos+j] ^ 8'(1 << $urandom_range(7, 0));
          end
        end
        for (k = 0; k < n; k++) begin
          beat.data_byte  = bytes_q[k];
          beat.range_last = (k == n - 1);
          send_byte(beat, CHK_MODEL, none_res);
        end
        phase_beats += n;
      end
      rand_beats += phase_beats;
      phase++;
    end

    quiesce();
    repeat (8) @(negedge clk_i);
    $display("%0d beats sent, %0d register writes, %0d random phases", beats_sent, cfg_cnt,
             phase);
    $display("%0d reports checked: %0d hits, %0d misses, %0d errors", hit_cnt + miss_cnt,
             hit_cnt, miss_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mbps_pkg.sv
rtl/mbps_cfg.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_search.sv
rtl/mbps_checker.sv
tb/masked_byte_pattern_search_test.sv
